>>> src/mr_pkg.sv
// ----------------------------------------------------------------------------
// mr_pkg: shared types and constants for the Miller-Rabin round block
// Operand width and the command/status structs between controller and datapath.
// ----------------------------------------------------------------------------
package mr_pkg;

  localparam int unsigned WIDTH = 64;
  localparam int unsigned CNT_W = $clog2(WIDTH + 1);

  typedef logic [WIDTH-1:0] word_t;
  typedef logic [CNT_W-1:0] cnt_t;

  // datapath operations
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,      // capture n and w, start w mod n
    OP_RED_STEP,  // one restoring step of w mod n
    OP_DECOMP,    // shift r right by one, count s
    OP_MUL_INIT,  // set up p = x*y mod n: x,y chosen by mul_sel
    OP_MUL_STEP,  // one shift-and-add step of the modular multiply
    OP_MUL_ACC,   // write product to acc
    OP_MUL_BASE,  // write product to base, shift exponent right
    OP_MUL_X,     // write product to x
    OP_SET_X      // x <= acc
  } op_t;

  typedef enum logic [1:0] {
    SEL_ACC_BASE,
    SEL_BASE_BASE,
    SEL_X_X
  } mul_sel_t;

  typedef struct packed {
    op_t      op;
    mul_sel_t sel;
  } mr_cmd_t;

  typedef struct packed {
    logic n_is_two;
    logic n_trivial_fail;
    logic a_trivial;
    logic red_done;
    logic r_odd;
    logic e_zero;
    logic e_lsb;
    logic mul_done;
    logic x_is_one;
    logic x_is_nm1;
    logic s_more;      // another squaring step is still allowed
  } mr_sts_t;

endpackage

>>> src/mr_datapath.sv
// ----------------------------------------------------------------------------
// mr_datapath: operand registers and shared modular arithmetic
// One restoring reduction step, one shift-and-add multiply step per cycle.
// ----------------------------------------------------------------------------
module mr_datapath import mr_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  word_t   in_candidate,
  input  word_t   in_witness,
  input  mr_cmd_t cmd,
  output mr_sts_t sts
);

  word_t n_r, nm1_r, a_r, e_r, acc_r, base_r, x_r;
  word_t mx_r, my_r, mp_r;
  // reduction: remainder one bit wider than n
  logic [WIDTH:0] rem_r;
  word_t          wq_r;
  cnt_t           rcnt_r, s_r, j_r;

  logic [WIDTH:0] rem_sh;
  logic [WIDTH:0] dbl, sum;
  word_t          dbl_m, sum_m, mx_sel, my_sel, prod;

  always_comb begin
    rem_sh = {rem_r[WIDTH-1:0], wq_r[WIDTH-1]};
    // modular doubling of mx and modular add into mp
    dbl    = {1'b0, mx_r} + {1'b0, mx_r};
    dbl_m  = (dbl >= {1'b0, n_r}) ? WIDTH'(dbl - {1'b0, n_r}) : dbl[WIDTH-1:0];
    sum    = {1'b0, mp_r} + {1'b0, mx_r};
    sum_m  = (sum >= {1'b0, n_r}) ? WIDTH'(sum - {1'b0, n_r}) : sum[WIDTH-1:0];
    case (cmd.sel)
      SEL_ACC_BASE:  begin mx_sel = base_r; my_sel = acc_r;  end
      SEL_BASE_BASE: begin mx_sel = base_r; my_sel = base_r; end
      SEL_X_X:       begin mx_sel = x_r;    my_sel = x_r;    end
      default:       begin mx_sel = x_r;    my_sel = x_r;    end
    endcase
    prod = mp_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      j_r <= cnt_t'(1);
    end else begin
      case (cmd.op)
        OP_LOAD: begin
          n_r    <= in_candidate;
          nm1_r  <= in_candidate - WIDTH'(1);
          e_r    <= in_candidate - WIDTH'(1);
          wq_r   <= in_witness;
          rem_r  <= '0;
          rcnt_r <= '0;
          s_r    <= '0;
          acc_r  <= WIDTH'(1);
        end
        OP_RED_STEP: begin
          if (rem_sh >= {1'b0, n_r}) rem_r <= rem_sh - {1'b0, n_r};
          else rem_r <= rem_sh;
          wq_r   <= {wq_r[WIDTH-2:0], 1'b0};
          rcnt_r <= rcnt_r + cnt_t'(1);
          if (rcnt_r == cnt_t'(WIDTH - 1)) begin
            a_r    <= (rem_sh >= {1'b0, n_r}) ? WIDTH'(rem_sh - {1'b0, n_r})
                                              : rem_sh[WIDTH-1:0];
          end
        end
        OP_DECOMP: begin
          e_r <= {1'b0, e_r[WIDTH-1:1]};
          s_r <= s_r + cnt_t'(1);
          base_r <= a_r;
          j_r <= cnt_t'(1);
        end
        OP_MUL_INIT: begin
          mx_r <= mx_sel;
          my_r <= my_sel;
          mp_r <= '0;
        end
        OP_MUL_STEP: begin
          if (my_r[0]) mp_r <= sum_m;
          mx_r <= dbl_m;
          my_r <= {1'b0, my_r[WIDTH-1:1]};
        end
        OP_MUL_ACC:   acc_r  <= prod;
        OP_MUL_BASE: begin
          base_r <= prod;
          e_r    <= {1'b0, e_r[WIDTH-1:1]};
        end
        OP_MUL_X: begin
          x_r <= prod;
          j_r <= j_r + cnt_t'(1);
        end
        OP_SET_X:     x_r <= acc_r;
        default: ;
      endcase
    end
  end

  always_comb begin
    sts.n_is_two       = (n_r == WIDTH'(2));
    sts.n_trivial_fail = (n_r < WIDTH'(2)) || !n_r[0];
    sts.a_trivial      = (a_r == '0) || (a_r == WIDTH'(1)) || (a_r == nm1_r);
    sts.red_done       = (rcnt_r == cnt_t'(WIDTH));
    sts.r_odd          = e_r[0];
    sts.e_zero         = (e_r == '0);
    sts.e_lsb          = e_r[0];
    sts.mul_done       = (my_r == '0);
    sts.x_is_one       = (x_r == WIDTH'(1));
    sts.x_is_nm1       = (x_r == nm1_r);
    sts.s_more         = (j_r < s_r);
  end

endmodule

>>> src/mr_ctrl.sv
// ----------------------------------------------------------------------------
// mr_ctrl: sequencer for one Miller-Rabin round
// Steps reduction, decomposition, exponentiation and squarings; holds verdict.
// ----------------------------------------------------------------------------
module mr_ctrl import mr_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  logic    in_last_round,
  output logic    out_valid,
  input  logic    out_ready,
  output logic    out_probable_prime,
  output logic    out_round_passed,
  output logic    out_final_res,
  output mr_cmd_t cmd,
  input  mr_sts_t sts
);

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_RED, S_TRIV, S_DECOMP,
    S_EXP_TEST, S_MUL, S_SQ_TEST, S_SQ_MUL, S_DONE
  } state_t;

  // which product is in flight
  typedef enum logic [1:0] { M_ACC, M_BASE, M_X } mdst_t;

  state_t state_r;
  mdst_t  mdst_r;
  logic   last_r, composite_r, passed_r;
  logic   out_valid_r, pp_r, rp_r, fr_r;

  assign in_ready           = (state_r == S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_probable_prime = pp_r;
  assign out_round_passed   = rp_r;
  assign out_final_res      = fr_r;

  always_comb begin
    cmd.op  = OP_NONE;
    cmd.sel = SEL_X_X;
    case (state_r)
      S_IDLE:   if (in_valid && in_ready) cmd.op = OP_LOAD;
      S_RED:    if (!sts.red_done) cmd.op = OP_RED_STEP;
      S_DECOMP: if (!sts.r_odd) cmd.op = OP_DECOMP;
      S_EXP_TEST: begin
        if (!sts.e_zero) begin
          cmd.op  = OP_MUL_INIT;
          cmd.sel = sts.e_lsb ? SEL_ACC_BASE : SEL_BASE_BASE;
        end else begin
          cmd.op = OP_SET_X;
        end
      end
      S_MUL: begin
        if (!sts.mul_done) cmd.op = OP_MUL_STEP;
        else case (mdst_r)
          M_ACC:   cmd.op = OP_MUL_ACC;
          M_BASE:  cmd.op = OP_MUL_BASE;
          M_X:     cmd.op = OP_MUL_X;
          default: cmd.op = OP_NONE;
        endcase
      end
      S_SQ_MUL: begin
        cmd.op  = OP_MUL_INIT;
        cmd.sel = (mdst_r == M_X) ? SEL_X_X : SEL_BASE_BASE;
      end
      default: ;
    endcase
  end

  // OP_MUL_INIT in S_EXP_TEST leaves base in place, since decomp copied a
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mdst_r      <= M_ACC;
      composite_r <= 1'b0;
      out_valid_r <= 1'b0;
      last_r      <= 1'b0;
      passed_r    <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && state_r != S_DONE) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: if (in_valid && in_ready) begin
          last_r  <= in_last_round;
          state_r <= S_CHECK;
        end
        S_CHECK: begin
          if (sts.n_is_two) begin
            passed_r <= 1'b1; state_r <= S_DONE;
          end else if (sts.n_trivial_fail) begin
            passed_r <= 1'b0; state_r <= S_DONE;
          end else state_r <= S_RED;
        end
        S_RED: if (sts.red_done) state_r <= S_TRIV;
        S_TRIV: begin
          if (sts.a_trivial) begin
            passed_r <= 1'b1; state_r <= S_DONE;
          end else state_r <= S_DECOMP;
        end
        S_DECOMP: if (sts.r_odd) state_r <= S_EXP_TEST;
        S_EXP_TEST: begin
          // odd exponent bit: acc*base, then base*base straight after via S_SQ_MUL
          if (sts.e_zero) state_r <= S_SQ_TEST;
          else begin
            mdst_r  <= sts.e_lsb ? M_ACC : M_BASE;
            state_r <= S_MUL;
          end
        end
        S_MUL: if (sts.mul_done) begin
          case (mdst_r)
            M_ACC: begin
              mdst_r  <= M_BASE;
              state_r <= S_SQ_MUL;
            end
            M_BASE:  state_r <= S_EXP_TEST;
            M_X:     state_r <= S_SQ_TEST;
            default: state_r <= S_SQ_TEST;
          endcase
        end
        S_SQ_MUL: begin
          state_r <= S_MUL;
        end
        S_SQ_TEST: begin
          if (sts.x_is_nm1 || (sts.x_is_one && mdst_r != M_X)) begin
            passed_r <= 1'b1; state_r <= S_DONE;
          end else if (sts.s_more) begin
            mdst_r  <= M_X;
            state_r <= S_SQ_MUL;
          end else begin
            passed_r <= 1'b0; state_r <= S_DONE;
          end
        end
        S_DONE: begin
          // hold the verdict until the output register is free
          if (!out_valid_r || out_ready) begin
            pp_r        <= passed_r && !composite_r;
            rp_r        <= passed_r;
            fr_r        <= last_r;
            out_valid_r <= 1'b1;
            composite_r <= last_r ? 1'b0 : (composite_r || !passed_r);
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

>>> src/miller_rabin_round.sv
// ----------------------------------------------------------------------------
// miller_rabin_round: one Miller-Rabin round per item
// Controller plus shared bit-serial modular multiply datapath.
// ----------------------------------------------------------------------------
// channel | ports                                        | direction
// in      | in_valid/in_ready, candidate, witness, last  | into block
// out     | out_valid/out_ready, probable_prime, passed,  | out of block
//         | final_res                                    |
// An item runs the restoring reduction of the witness and the decomposition of
// n-1, then its modular multiplies, each stepped bit by bit in the shared
// shift-and-add multiplier datapath.
// Trivial candidates go from S_CHECK straight to S_DONE for their result.
// Reset clears the controller and the composite flag. One item is in
// flight; a finished verdict waits in the output register, and a new item
// is taken meanwhile but holds in its last state until that register frees.
// ----------------------------------------------------------------------------
module miller_rabin_round import mr_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  word_t in_candidate,
  input  word_t in_witness,
  input  logic  in_last_round,
  output logic  out_valid,
  input  logic  out_ready,
  output logic  out_probable_prime,
  output logic  out_round_passed,
  output logic  out_final_res
);

  mr_cmd_t cmd;
  mr_sts_t sts;

  mr_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .in_last_round,
    .out_valid, .out_ready, .out_probable_prime, .out_round_passed,
    .out_final_res, .cmd, .sts
  );

  mr_datapath u_dp (
    .clk, .rst_n, .in_candidate, .in_witness, .cmd, .sts
  );

endmodule

>>> src/mr_checker.sv
// ----------------------------------------------------------------------------
// mr_checker: port-level checks for the Miller-Rabin round block
// Watches handshake order and verdict consistency.
// ----------------------------------------------------------------------------
module mr_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_probable_prime,
  input logic out_round_passed,
  input logic out_final_res
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      $stable({out_probable_prime, out_round_passed, out_final_res}))
    else $error("result changed while waiting");

  a_pp_implies_pass: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_probable_prime |-> out_round_passed)
    else $error("prime verdict on failed round");

  a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready) else $error("second item taken while busy");

endmodule

bind miller_rabin_round mr_checker u_mr_checker (
  .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready,
  .out_probable_prime, .out_round_passed, .out_final_res
);

>>> tb/miller_rabin_round_tb.sv
// ----------------------------------------------------------------------------
// miller_rabin_round_tb: self-checking bench for one Miller-Rabin round
// Drives candidate/witness rounds through valid/ready with random gaps and
// stalls, predicts each round's verdict and the sticky per-candidate flag,
// and compares every returned item against the oldest prediction.
// ----------------------------------------------------------------------------
module miller_rabin_round_tb;
  import mr_pkg::*;

  typedef struct packed {
    word_t cand;
    word_t wit;
    logic  last;
  } round_t;

  typedef struct packed {
    logic prime;
    logic passed;
    logic fin;
  } verdict_t;

  logic  clk = 1'b0;
  logic  rst_n = 1'b0;
  logic  in_valid = 1'b0;
  logic  in_ready;
  word_t in_candidate = '0;
  word_t in_witness = '0;
  logic  in_last_round = 1'b0;
  logic  out_valid;
  logic  out_ready = 1'b0;
  logic  out_probable_prime, out_round_passed, out_final_res;

  round_t   pending_rounds[$];
  verdict_t expected_verdicts[$];
  logic     seen_composite = 1'b0;
  int       mismatches = 0;
  int       verdicts_checked = 0;
  int       primes_reported = 0;
  int       cycles = 0;
  int       send_gap = 0;
  int       stall_len = 0;
  bit       stim_done = 1'b0;

  miller_rabin_round DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ------------------------------------------------------------ arithmetic
  function automatic word_t mod_add(word_t a, word_t b, word_t n);
    word_t gap;
    gap = n - b;
    return (a >= gap) ? a - gap : a + b;
  endfunction

  function automatic word_t mod_mul(word_t a, word_t b, word_t n);
    word_t acc;
    acc = '0;
    while (b != 0) begin
      if (b[0]) acc = mod_add(acc, a, n);
      a = mod_add(a, a, n);
      b = b >> 1;
    end
    return acc;
  endfunction

  function automatic logic round_passes(word_t n, word_t w);
    word_t nm1, r, x, a, base, e;
    int s;
    if (n == 2) return 1'b1;
    if (n < 2 || !n[0]) return 1'b0;
    nm1 = n - 1;
    a = w % n;
    if (a == 0 || a == 1 || a == nm1) return 1'b1;
    r = nm1;
    s = 0;
    while (!r[0]) begin
      r = r >> 1;
      s++;
    end
    x = 1;
    base = a;
    e = r;
    while (e != 0) begin
      if (e[0]) x = mod_mul(x, base, n);
      base = mod_mul(base, base, n);
      e = e >> 1;
    end
    if (x == 1 || x == nm1) return 1'b1;
    for (int j = 1; j < s; j++) begin
      x = mod_mul(x, x, n);
      if (x == nm1) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic word_t rand_word();
    return {$urandom(), $urandom()};
  endfunction

  task automatic add_round(word_t c, word_t w, logic last);
    round_t rd;
    rd.cand = c;
    rd.wit = w;
    rd.last = last;
    pending_rounds.push_back(rd);
  endtask

  function automatic int pick_gap();
    if ($urandom_range(0, 2) == 0) return 0;
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
  endfunction

  // ------------------------------------------------------------ stimulus
  initial begin
    word_t primes[8];
    word_t c;
    int nr;
    primes = '{64'd3, 64'd97, 64'd7919, 64'd1000000007, 64'd2147483647,
               64'd4294967311, 64'd2305843009213693951, 64'hFFFFFFFFFFFFFFC5};
    // directed: trivial candidates, trivial witnesses, extremes
    add_round(64'd0, rand_word(), 1'b1);
    add_round(64'd1, 64'd0, 1'b1);
    add_round(64'd2, '1, 1'b0);
    add_round(64'd2, 64'd0, 1'b1);
    add_round(64'd4, 64'd3, 1'b1);
    add_round('1 - 1, 64'd5, 1'b1);
    add_round(64'd97, 64'd0, 1'b0);
    add_round(64'd97, 64'd98, 1'b0);
    add_round(64'd97, 64'd96, 1'b0);
    add_round(64'd97, '1, 1'b1);
    add_round(64'd561, 64'd2, 1'b0);       // Carmichael number
    add_round(64'd561, 64'd562, 1'b1);
    add_round(64'd9, 64'd2, 1'b0);
    add_round(64'd9, 64'd8, 1'b0);         // composite, passes this round
    add_round(64'd3, 64'd2, 1'b1);         // flag cleared after last round
    add_round('1, '1, 1'b0);
    add_round('1, 64'd2, 1'b1);
    add_round(64'hFFFFFFFFFFFFFFC5, 64'hAAAAAAAAAAAAAAAA, 1'b0);
    add_round(64'hFFFFFFFFFFFFFFC5, 64'h5555555555555555, 1'b1);
    add_round(64'h8000000000000001, 64'h7FFFFFFFFFFFFFFF, 1'b1);
    add_round(64'd3215031751, 64'd2, 1'b1); // strong pseudoprime to 2,3,5,7
    // random: candidate groups of a few rounds each
    while (pending_rounds.size() < 100) begin
      case ($urandom_range(0, 3))
        0: c = primes[$urandom_range(0, 7)];
        1: c = rand_word() | 64'd1;
        2: c = {32'd0, $urandom()} | 64'd1;
        default: c = rand_word();
      endcase
      nr = $urandom_range(1, 4);
      for (int k = 0; k < nr; k++)
        add_round(c, ($urandom_range(0, 7) == 0) ? word_t'($urandom_range(0, 2)) :
                  rand_word(), (k == nr - 1) ? 1'b1 : 1'b0);
    end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    stim_done = 1'b1;
  end

  // ------------------------------------------------------------ driver
  always @(posedge clk) begin
    round_t rd;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        verdict_t v;
        v.passed = round_passes(in_candidate, in_witness);
        if (!v.passed) seen_composite = 1'b1;
        v.prime = !seen_composite;
        v.fin = in_last_round;
        if (in_last_round) seen_composite = 1'b0;
        expected_verdicts.push_back(v);
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_rounds.size() > 0) begin
          rd = pending_rounds.pop_front();
          in_valid <= 1'b1;
          in_candidate <= rd.cand;
          in_witness <= rd.wit;
          in_last_round <= rd.last;
          send_gap <= pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ------------------------------------------------------------ monitor
  always @(posedge clk) begin
    verdict_t got, exp_v;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        got = {out_probable_prime, out_round_passed, out_final_res};
        if (expected_verdicts.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected item: %b", got);
        end else begin
          exp_v = expected_verdicts.pop_front();
          verdicts_checked++;
          if (got.fin && got.prime) primes_reported++;
          if (got !== exp_v) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch item %0d: prime %b/%b passed %b/%b final %b/%b (exp/act)",
                       verdicts_checked, exp_v.prime, got.prime, exp_v.passed,
                       got.passed, exp_v.fin, got.fin);
          end
        end
      end
      // hold off ready in random stretches
      if (stall_len > 0) begin
        stall_len <= stall_len - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall_len <= pick_gap();
      end
    end
  end

  // ------------------------------------------------------------ end of run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 4000000) begin
      $display("timeout with %0d items outstanding", expected_verdicts.size());
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    wait (stim_done);
    @(posedge clk);
    while (pending_rounds.size() > 0 || in_valid || expected_verdicts.size() > 0)
      @(posedge clk);
    repeat (50) @(posedge clk);
    $display("checked %0d round verdicts, %0d candidates reported probably prime",
             verdicts_checked, primes_reported);
    if (mismatches == 0 && expected_verdicts.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
